// ===== rtl/hjq_pkg.sv =====
package hjq_pkg;

  localparam int unsigned TableSlotsDef = 16;
  localparam int unsigned MaxWorkersDef = 4;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ModeW = 3;
  localparam int unsigned StatusW = 4;
  localparam int unsigned LimitW = 3;
  localparam int unsigned HashShift = 10;

  typedef enum logic [ModeW-1:0] {
    MODE_ENQ      = 3'd0,
    MODE_CANCEL   = 3'd1,
    MODE_DISPATCH = 3'd2,
    MODE_FINISH   = 3'd3,
    MODE_COMPLETE = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_QUEUED     = 4'd0,
    ST_CANCELLED  = 4'd1,
    ST_NOT_FOUND  = 4'd2,
    ST_RUNNING    = 4'd3,
    ST_FULL       = 4'd4,
    ST_DISPATCHED = 4'd5,
    ST_EMPTY      = 4'd6,
    ST_RUN_NOW    = 4'd7,
    ST_COMPLETED  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    PH_FREE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_HASHED  = 2'd2,
    PH_INLINE  = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WALK, S_UNCHAIN, S_UNLINK, S_ENQ, S_FINISH, S_OUT
  } state_e;

  function automatic logic [KeyW-1:0] hash_fold(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] t;
    t = (k >> HashShift) ^ k;
    return (t >> HashShift) ^ k;
  endfunction

endpackage

// ===== rtl/hjq_if.sv =====
interface hjq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] job_key;
  logic [3:0]  slot_id;
  logic [1:0]  worker_id;
  modport source (output valid, mode, job_key, slot_id, worker_id, input ready);
  modport sink (input valid, mode, job_key, slot_id, worker_id, output ready);
endinterface

interface hjq_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] out_key;
  logic [3:0]  out_slot;
  logic [4:0]  pending_count;
  logic        start_worker;
  logic [1:0]  worker_index;
  modport source (output valid, status, out_key, out_slot, pending_count, start_worker,
    worker_index, input ready);
  modport sink (input valid, status, out_key, out_slot, pending_count, start_worker,
    worker_index, output ready);
endinterface

// ===== rtl/hjq_ram.sv =====
module hjq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/hashed_job_queue_table_core.sv =====
// hashed job queue table
// requests arrive on req (valid/ready) carrying mode, job_key, slot_id and worker_id;
// each transaction gives exactly one response transaction on rsp
// a small sequencer walks hash chains and fifo links; a chain search passes
// through decode and walk for each entry, an unchain pass walks on in unchain;
// link tables sit in flip-flops, keys sit in a registered-read ram
// path from acceptance to response: decode then out for a full enqueue, an
// empty dispatch or an unused mode; enqueue passes through enq, dispatch through
// unlink, complete of a claimed job through finish, complete of a dispatched job
// through unchain and finish; cancel and finish walk the chain and, on a waiting
// match, pass through unchain and unlink (cancel then also through finish)
// throughput: one transaction at a time; req_ready is low while one is in flight
// or while its response waits on rsp
// worker_limit is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while idle, the block itself does not enforce it; reset: all buckets empty,
// free list in slot order, fifo empty, no jobs, all workers idle, worker_limit 1;
// no clearing pass is needed; when the receiver stalls the response is held stable
// in the output register and no new request is taken until it goes
module hashed_job_queue_table_core
  import hjq_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TableSlotsDef,
  parameter int unsigned MAX_WORKERS = MaxWorkersDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  hjq_req_if.sink           req,
  hjq_rsp_if.source         rsp
);
  localparam int unsigned SW = $clog2(TABLE_SLOTS);
  localparam int unsigned PW = SW + 1;   // slot pointer with nil
  localparam logic [PW-1:0] Nil = PW'(TABLE_SLOTS);
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

  // link tables
  logic [PW-1:0] bucket_head_q [TABLE_SLOTS];
  logic [PW-1:0] chain_next_q  [TABLE_SLOTS];
  logic [PW-1:0] fifo_prev_q   [TABLE_SLOTS];
  logic [PW-1:0] fifo_next_q   [TABLE_SLOTS];
  phase_e        phase_q       [TABLE_SLOTS];
  logic [PW-1:0] free_head_q, fifo_head_q, fifo_tail_q;
  logic [CW-1:0] job_total_q;
  logic [MAX_WORKERS-1:0] busy_q;
  logic [LimitW-1:0] limit_q;

  state_e state_q, state_d;
  logic [ModeW-1:0] mode_q;
  logic [KeyW-1:0]  key_q;
  logic [SW-1:0]    bucket_q;
  logic [PW-1:0]    cur_q, prev_q, tgt_q;
  logic [1:0]       wid_q;
  logic [SW-1:0]    sid_q;

  // response register
  logic rsp_valid_q;
  logic [StatusW-1:0] status_q;
  logic [KeyW-1:0] okey_q;
  logic [SW-1:0] oslot_q;
  logic start_q;
  logic [1:0] widx_q;

  // key ram
  logic key_we;
  logic [SW-1:0] key_waddr, key_raddr;
  logic [KeyW-1:0] key_rdata;

  hjq_ram #(.Width(KeyW), .Depth(TABLE_SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  assign key_we    = (state_q == S_ENQ);
  assign key_waddr = free_head_q[SW-1:0];

  logic accept;
  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign accept    = req.valid && req.ready;

  // clamped limit and lowest idle worker, small independent loops
  logic [LimitW-1:0] lim;
  logic [LimitW-1:0] nbusy;
  logic              found_idle;
  logic [1:0]        idle_idx;
  always_comb begin
    lim = limit_q;
    if (lim == '0) lim = LimitW'(1);
    if (32'(lim) > MAX_WORKERS) lim = LimitW'(MAX_WORKERS);
    nbusy = '0;
    found_idle = 1'b0;
    idle_idx = '0;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      if (i < 32'(lim)) begin
        if (busy_q[i]) nbusy = nbusy + LimitW'(1);
        else if (!found_idle) begin
          found_idle = 1'b1;
          idle_idx = 2'(i);
        end
      end
    end
  end

  // key ram read address: while idle the slot the request will look at first,
  // so its key is ready in decode; cur slot otherwise
  always_comb begin
    key_raddr = cur_q[SW-1:0];
    if (state_q == S_IDLE) begin
      if (req.mode == MODE_COMPLETE) key_raddr = req.slot_id[SW-1:0];
      else if (req.mode == MODE_DISPATCH) key_raddr = fifo_head_q[SW-1:0];
      else key_raddr = bucket_head_q[SW'(hash_fold(req.job_key))][SW-1:0];
    end
  end

  // the mode as held
  logic is_cancel, is_finish;
  assign is_cancel = (mode_q == MODE_CANCEL);
  assign is_finish = (mode_q == MODE_FINISH);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (accept) state_d = S_DECODE;
      S_DECODE:  state_d = S_OUT;
      S_WALK:    state_d = S_WALK;
      S_UNCHAIN: state_d = S_UNCHAIN;
      S_UNLINK:  state_d = S_OUT;
      S_ENQ:     state_d = S_OUT;
      S_FINISH:  state_d = S_OUT;
      S_OUT:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer: all link updates done here, one step per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        bucket_head_q[i] <= Nil;
        chain_next_q[i]  <= PW'(i + 1);
        fifo_prev_q[i]   <= Nil;
        fifo_next_q[i]   <= Nil;
        phase_q[i]       <= PH_FREE;
      end
      free_head_q <= '0;
      fifo_head_q <= Nil;
      fifo_tail_q <= Nil;
      job_total_q <= '0;
      busy_q      <= '0;
      limit_q     <= LimitW'(1);
      rsp_valid_q <= 1'b0;
      mode_q <= '0; key_q <= '0; bucket_q <= '0; cur_q <= Nil; prev_q <= Nil;
      tgt_q <= Nil; wid_q <= '0; sid_q <= '0;
      status_q <= '0; okey_q <= '0; oslot_q <= '0; start_q <= 1'b0; widx_q <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= req.mode;
            key_q    <= req.job_key;
            bucket_q <= SW'(hash_fold(req.job_key));
            sid_q    <= req.slot_id[SW-1:0];
            wid_q    <= req.worker_id;
            state_q  <= S_DECODE;
            status_q <= ST_NOT_FOUND;
            okey_q   <= '0;
            oslot_q  <= '0;
            start_q  <= 1'b0;
            widx_q   <= '0;
            // complete reads the slot key; dispatch reads the head key
            if (req.mode == MODE_COMPLETE) cur_q <= PW'(req.slot_id);
            else if (req.mode == MODE_DISPATCH) cur_q <= fifo_head_q;
            else cur_q <= bucket_head_q[SW'(hash_fold(req.job_key))];
            prev_q <= Nil;
          end
        end
        S_DECODE: begin
          // on entry from idle the key ram holds cur_q's key
          state_q <= S_OUT;
          case (mode_q)
            MODE_ENQ: begin
              if (free_head_q == Nil) status_q <= ST_FULL;
              else state_q <= S_ENQ;
            end
            MODE_CANCEL, MODE_FINISH: begin
              state_q <= S_WALK;
            end
            MODE_DISPATCH: begin
              if (cur_q == Nil) begin
                status_q <= ST_EMPTY;
                if (32'(wid_q) < MAX_WORKERS) busy_q[wid_q] <= 1'b0;
              end else begin
                status_q <= ST_DISPATCHED;
                oslot_q  <= cur_q[SW-1:0];
                tgt_q    <= cur_q;
                phase_q[cur_q[SW-1:0]] <= PH_HASHED;
                if (32'(wid_q) < MAX_WORKERS) busy_q[wid_q] <= 1'b1;
                state_q <= S_UNLINK;
              end
            end
            MODE_COMPLETE: begin
              if (phase_q[sid_q] == PH_HASHED || phase_q[sid_q] == PH_INLINE) begin
                status_q <= ST_COMPLETED;
                okey_q   <= key_rdata;
                oslot_q  <= sid_q;
                tgt_q    <= PW'(sid_q);
                if (phase_q[sid_q] == PH_HASHED) begin
                  bucket_q <= SW'(hash_fold(key_rdata));
                  cur_q    <= bucket_head_q[SW'(hash_fold(key_rdata))];
                  prev_q   <= Nil;
                  state_q  <= S_UNCHAIN;
                end else state_q <= S_FINISH;
              end
            end
            default: ;
          endcase
        end
        S_WALK: begin
          // key_rdata holds key of cur_q
          if (cur_q == Nil) begin
            state_q <= S_OUT;
          end else if (key_rdata == key_q) begin
            okey_q <= key_q;
            if (phase_q[cur_q[SW-1:0]] == PH_WAIT) begin
              tgt_q <= cur_q;
              cur_q <= bucket_head_q[bucket_q];
              prev_q <= Nil;
              state_q <= S_UNCHAIN;
            end else begin
              status_q <= ST_RUNNING;
              state_q <= S_OUT;
            end
          end else begin
            cur_q <= chain_next_q[cur_q[SW-1:0]];
            state_q <= S_DECODE;
          end
        end
        S_UNCHAIN: begin
          if (cur_q == Nil) begin
            state_q <= S_FINISH;
          end else if (cur_q == tgt_q) begin
            if (prev_q == Nil) bucket_head_q[bucket_q] <= chain_next_q[cur_q[SW-1:0]];
            else chain_next_q[prev_q[SW-1:0]] <= chain_next_q[cur_q[SW-1:0]];
            state_q <= (mode_q == MODE_COMPLETE) ? S_FINISH : S_UNLINK;
          end else begin
            prev_q <= cur_q;
            cur_q  <= chain_next_q[cur_q[SW-1:0]];
          end
        end
        S_UNLINK: begin
          if (fifo_prev_q[tgt_q[SW-1:0]] != Nil)
            fifo_next_q[fifo_prev_q[tgt_q[SW-1:0]][SW-1:0]] <= fifo_next_q[tgt_q[SW-1:0]];
          else fifo_head_q <= fifo_next_q[tgt_q[SW-1:0]];
          if (fifo_next_q[tgt_q[SW-1:0]] != Nil)
            fifo_prev_q[fifo_next_q[tgt_q[SW-1:0]][SW-1:0]] <= fifo_prev_q[tgt_q[SW-1:0]];
          else fifo_tail_q <= fifo_prev_q[tgt_q[SW-1:0]];
          if (mode_q == MODE_DISPATCH) begin
            okey_q  <= key_rdata;
            state_q <= S_OUT;
          end else if (is_finish) begin
            phase_q[tgt_q[SW-1:0]] <= PH_INLINE;
            status_q <= ST_RUN_NOW;
            oslot_q  <= tgt_q[SW-1:0];
            state_q  <= S_OUT;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          // release the target slot
          chain_next_q[tgt_q[SW-1:0]] <= free_head_q;
          free_head_q <= tgt_q;
          phase_q[tgt_q[SW-1:0]] <= PH_FREE;
          if (job_total_q != '0) job_total_q <= job_total_q - CW'(1);
          if (is_cancel) status_q <= ST_CANCELLED;
          state_q <= S_OUT;
        end
        S_ENQ: begin
          free_head_q <= chain_next_q[free_head_q[SW-1:0]];
          phase_q[free_head_q[SW-1:0]] <= PH_WAIT;
          fifo_next_q[free_head_q[SW-1:0]] <= Nil;
          fifo_prev_q[free_head_q[SW-1:0]] <= fifo_tail_q;
          if (fifo_tail_q != Nil) fifo_next_q[fifo_tail_q[SW-1:0]] <= free_head_q;
          else fifo_head_q <= free_head_q;
          fifo_tail_q <= free_head_q;
          chain_next_q[free_head_q[SW-1:0]] <= bucket_head_q[bucket_q];
          bucket_head_q[bucket_q] <= free_head_q;
          job_total_q <= job_total_q + CW'(1);
          status_q <= ST_QUEUED;
          if (found_idle && (CW'(nbusy) < job_total_q + CW'(1))) begin
            busy_q[idle_idx] <= 1'b1;
            start_q <= 1'b1;
            widx_q  <= idle_idx;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          rsp_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.status        = status_q;
  assign rsp.out_key       = okey_q;
  assign rsp.out_slot      = 4'(oslot_q);
  assign rsp.pending_count = 5'(job_total_q);
  assign rsp.start_worker  = start_q;
  assign rsp.worker_index  = widx_q;

  logic unused_state_d;
  assign unused_state_d = ^state_d;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp_valid_q) else $error("ready while response pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(status_q))
    else $error("response dropped");
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(job_total_q) <= TABLE_SLOTS) else $error("job count overflow");
endmodule

// ===== sim/tb_job_table_scoreboard.sv =====
`timescale 1ns / 1ps

class job_table_scoreboard;
  localparam int unsigned Slots = 16;
  localparam int unsigned Nil = 16;
  localparam int unsigned Workers = 4;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] out_key;
    logic [3:0]  out_slot;
    logic [4:0]  pending_count;
    logic        start_worker;
    logic [1:0]  worker_index;
  } job_answer_t;

  logic [4:0]  bucket_head [Slots];
  logic [31:0] slot_key [Slots];
  logic [4:0]  chain_next [Slots];
  logic [4:0]  fifo_prev [Slots];
  logic [4:0]  fifo_next [Slots];
  logic [1:0]  slot_phase [Slots];
  logic [4:0]  free_head, fifo_head, fifo_tail, job_total;
  logic [3:0]  worker_busy;
  logic [2:0]  worker_limit;
  job_answer_t pending_answers [$];
  int          error_count;

  function new();
    for (int i = 0; i < Slots; i++) begin
      bucket_head[i] = Nil;
      slot_key[i] = '0;
      chain_next[i] = 5'(i + 1);
      fifo_prev[i] = '0;
      fifo_next[i] = '0;
      slot_phase[i] = hjq_pkg::PH_FREE;
    end
    free_head = '0;
    fifo_head = Nil;
    fifo_tail = Nil;
    job_total = '0;
    worker_busy = '0;
    worker_limit = 3'd1;
    error_count = 0;
  endfunction

  function automatic logic [3:0] bucket_of(logic [31:0] k);
    logic [31:0] t;
    t = (k >> 10) ^ k;
    t = (t >> 10) ^ k;
    return t[3:0];
  endfunction

  function automatic logic [4:0] find_key(logic [31:0] k);
    logic [4:0] s;
    s = bucket_head[bucket_of(k)];
    for (int n = 0; n < Slots && s < Nil; n++) begin
      if (slot_key[s] == k) return s;
      s = chain_next[s];
    end
    return Nil;
  endfunction

  function automatic void unchain(logic [4:0] slot);
    logic [3:0] b;
    logic [4:0] s, prv;
    b = bucket_of(slot_key[slot]);
    s = bucket_head[b];
    prv = Nil;
    for (int n = 0; n < Slots && s < Nil; n++) begin
      if (s == slot) begin
        if (prv == Nil) bucket_head[b] = chain_next[s];
        else chain_next[prv] = chain_next[s];
        return;
      end
      prv = s;
      s = chain_next[s];
    end
  endfunction

  function automatic void fifo_unlink(logic [4:0] s);
    logic [4:0] p, q;
    p = fifo_prev[s];
    q = fifo_next[s];
    if (p < Nil) fifo_next[p] = q;
    else fifo_head = q;
    if (q < Nil) fifo_prev[q] = p;
    else fifo_tail = p;
  endfunction

  function automatic void release_slot(logic [4:0] s);
    chain_next[s] = free_head;
    free_head = s;
    slot_phase[s] = hjq_pkg::PH_FREE;
    if (job_total > 0) job_total--;
  endfunction

  function void set_limit(logic [2:0] v);
    worker_limit = v;
  endfunction

  function void note_request(logic [2:0] mode, logic [31:0] key, logic [3:0] sid,
                             logic [1:0] wid);
    job_answer_t a;
    logic [4:0] s;
    logic [3:0] b;
    int unsigned lim, busy;
    a = '0;
    a.status = hjq_pkg::ST_NOT_FOUND;
    lim = (worker_limit == 0) ? 1 : (worker_limit > Workers ? Workers : worker_limit);
    case (mode)
      hjq_pkg::MODE_ENQ: begin
        if (free_head >= Nil) begin
          a.status = hjq_pkg::ST_FULL;
        end else begin
          b = bucket_of(key);
          s = free_head;
          free_head = chain_next[s];
          slot_key[s] = key;
          slot_phase[s] = hjq_pkg::PH_WAIT;
          fifo_next[s] = Nil;
          fifo_prev[s] = fifo_tail;
          if (fifo_tail < Nil) fifo_next[fifo_tail] = s;
          else fifo_head = s;
          fifo_tail = s;
          chain_next[s] = bucket_head[b];
          bucket_head[b] = s;
          job_total++;
          a.status = hjq_pkg::ST_QUEUED;
          busy = 0;
          for (int i = 0; i < lim; i++) if (worker_busy[i]) busy++;
          if (busy < job_total && busy < lim) begin
            for (int i = 0; i < lim; i++) begin
              if (!worker_busy[i]) begin
                worker_busy[i] = 1'b1;
                a.start_worker = 1'b1;
                a.worker_index = 2'(i);
                break;
              end
            end
          end
        end
      end
      hjq_pkg::MODE_CANCEL, hjq_pkg::MODE_FINISH: begin
        s = find_key(key);
        if (s < Nil) begin
          a.out_key = key;
          if (slot_phase[s] == hjq_pkg::PH_WAIT) begin
            unchain(s);
            fifo_unlink(s);
            if (mode == hjq_pkg::MODE_CANCEL) begin
              release_slot(s);
              a.status = hjq_pkg::ST_CANCELLED;
            end else begin
              slot_phase[s] = hjq_pkg::PH_INLINE;
              a.status = hjq_pkg::ST_RUN_NOW;
              a.out_slot = s[3:0];
            end
          end else begin
            a.status = hjq_pkg::ST_RUNNING;
          end
        end
      end
      hjq_pkg::MODE_DISPATCH: begin
        s = fifo_head;
        if (s < Nil) begin
          fifo_unlink(s);
          slot_phase[s] = hjq_pkg::PH_HASHED;
          a.status = hjq_pkg::ST_DISPATCHED;
          a.out_key = slot_key[s];
          a.out_slot = s[3:0];
          worker_busy[wid] = 1'b1;
        end else begin
          a.status = hjq_pkg::ST_EMPTY;
          worker_busy[wid] = 1'b0;
        end
      end
      hjq_pkg::MODE_COMPLETE: begin
        if (slot_phase[sid] >= hjq_pkg::PH_HASHED) begin
          if (slot_phase[sid] == hjq_pkg::PH_HASHED) unchain(5'(sid));
          a.out_key = slot_key[sid];
          a.out_slot = sid;
          release_slot(5'(sid));
          a.status = hjq_pkg::ST_COMPLETED;
        end
      end
      default: ;
    endcase
    a.pending_count = job_total;
    pending_answers.push_back(a);
  endfunction

  function void check_answer(job_answer_t got);
    job_answer_t exp;
    if (pending_answers.size() == 0) begin
      $error("response with nothing outstanding");
      error_count++;
      return;
    end
    exp = pending_answers.pop_front();
    if (got.status !== exp.status) begin
      $error("status expected %0d got %0d", exp.status, got.status);
      error_count++;
    end
    if (got.out_key !== exp.out_key) begin
      $error("out_key expected %h got %h", exp.out_key, got.out_key);
      error_count++;
    end
    if (got.out_slot !== exp.out_slot) begin
      $error("out_slot expected %0d got %0d", exp.out_slot, got.out_slot);
      error_count++;
    end
    if (got.pending_count !== exp.pending_count) begin
      $error("pending_count expected %0d got %0d", exp.pending_count, got.pending_count);
      error_count++;
    end
    if (got.start_worker !== exp.start_worker) begin
      $error("start_worker expected %0d got %0d", exp.start_worker, got.start_worker);
      error_count++;
    end
    if (got.worker_index !== exp.worker_index) begin
      $error("worker_index expected %0d got %0d", exp.worker_index, got.worker_index);
      error_count++;
    end
  endfunction

  // running or claimed slots, for complete requests
  function automatic logic [3:0] pick_running();
    logic [3:0] c [$];
    for (int i = 0; i < Slots; i++)
      if (slot_phase[i] >= hjq_pkg::PH_HASHED) c.push_back(4'(i));
    if (c.size() == 0) return 4'($urandom_range(0, 15));
    return c[$urandom_range(0, c.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_live_key();
    logic [31:0] c [$];
    for (int i = 0; i < Slots; i++)
      if (slot_phase[i] != hjq_pkg::PH_FREE) c.push_back(slot_key[i]);
    if (c.size() == 0) return $urandom;
    return c[$urandom_range(0, c.size() - 1)];
  endfunction
endclass

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hjq_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandomItems = 900;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  hjq_req_if req ();
  hjq_rsp_if rsp ();

  hashed_job_queue_table_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req.sink),
    .rsp        (rsp.source)
  );

  job_table_scoreboard job_book;
  int  idle_cycles;
  bit  hold_off;
  bit  run_done;
  // small key pool so hash collisions and repeated handles turn up often
  logic [31:0] key_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // random gap length, mostly short with the odd long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned g;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0 && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
    end
  end

  // every accepted response transaction is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      job_book.check_answer({rsp.status, rsp.out_key, rsp.out_slot, rsp.pending_count,
                             rsp.start_worker, rsp.worker_index});
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // offer one request and hold it until the block takes it
  task automatic send_request(logic [2:0] mode, logic [31:0] key, logic [3:0] sid,
                              logic [1:0] wid);
    req.valid     <= 1'b1;
    req.mode      <= mode;
    req.job_key   <= key;
    req.slot_id   <= sid;
    req.worker_id <= wid;
    do @(posedge clk_i); while (!req.ready);
    job_book.note_request(mode, key, sid, wid);
  endtask

  task automatic pause_sender();
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // wait for all predicted responses, then let the block settle
  task automatic drain();
    req.valid <= 1'b0;
    while (job_book.pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [2:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    job_book.set_limit(v);
  endtask

  // random request, weighted toward useful sequences
  task automatic random_request();
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) k = $urandom;
    else k = key_pool[$urandom_range(0, 7)];
    if (r < 35) begin
      send_request(MODE_ENQ, k, 4'($urandom), 2'($urandom));
    end else if (r < 47) begin
      send_request(MODE_CANCEL, $urandom_range(0, 3) == 0 ? k : job_book.pick_live_key(),
                   4'($urandom), 2'($urandom));
    end else if (r < 67) begin
      send_request(MODE_DISPATCH, $urandom, 4'($urandom), 2'($urandom));
    end else if (r < 77) begin
      send_request(MODE_FINISH, $urandom_range(0, 3) == 0 ? k : job_book.pick_live_key(),
                   4'($urandom), 2'($urandom));
    end else if (r < 95) begin
      send_request(MODE_COMPLETE, $urandom,
                   $urandom_range(0, 4) == 0 ? 4'($urandom) : job_book.pick_running(),
                   2'($urandom));
    end else begin
      // unused mode codes
      send_request(3'($urandom_range(5, 7)), $urandom, 4'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    logic [2:0] limits [6];
    job_book = new();
    limits = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req.valid = 1'b0;
    req.mode = '0;
    req.job_key = '0;
    req.slot_id = '0;
    req.worker_id = '0;
    hold_off = 1'b0;
    idle_cycles = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    // two keys in one bucket
    key_pool[6] = 32'h0000_0000;
    key_pool[7] = 32'h0000_0010;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, not found, extremes of the key, fill to full
    send_request(MODE_DISPATCH, '0, '0, 2'd3);
    send_request(MODE_CANCEL, 32'hFFFF_FFFF, '0, '0);
    send_request(MODE_FINISH, '0, '0, '0);
    send_request(MODE_COMPLETE, '0, 4'hF, '0);
    send_request(3'd7, 32'hFFFF_FFFF, 4'hF, 2'd3);
    for (int i = 0; i < 17; i++)
      send_request(MODE_ENQ, i == 0 ? 32'hFFFF_FFFF : (i == 1 ? 32'h0 : 32'(i) << 4),
                   '0, '0);
    send_request(MODE_DISPATCH, '0, '0, 2'd0);
    // running job: cancel reports running
    send_request(MODE_CANCEL, 32'hFFFF_FFFF, '0, '0);
    send_request(MODE_FINISH, 32'h0, '0, '0);
    send_request(MODE_CANCEL, 32'h20, '0, '0);
    send_request(MODE_COMPLETE, '0, 4'd0, '0);
    send_request(MODE_COMPLETE, '0, 4'd1, '0);
    drain();

    // random phases across worker limit settings
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      if (p == 2) hold_off = 1'b1;
      for (int n = 0; n < RandomItems / 6; n++) begin
        random_request();
        pause_sender();
      end
      drain();
    end

    if (job_book.error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/hjq_pkg.sv
rtl/hjq_if.sv
rtl/hjq_ram.sv
rtl/hashed_job_queue_table_core.sv
sim/tb_job_table_scoreboard.sv
sim/tb_top.sv
